// ----- rtl/scps_pkg.sv -----
// shared types, constants and helpers for the strict priority call scheduler
package scps_pkg;

  // sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_CLASSES = 4;

  localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int CLS_IDX_W = $clog2(NUM_CLASSES);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W    = CLS_IDX_W + SLOT_W;
  localparam int MEM_DEPTH = NUM_CLASSES * (2 ** SLOT_W);

  // field widths
  localparam int CLASS_W = 2;
  localparam int ID_W    = 16;
  localparam int DUR_W   = 16;
  localparam int ENTRY_W = ID_W + DUR_W;

  typedef enum logic {
    KIND_ARRIVAL = 1'b0,
    KIND_TICK    = 1'b1
  } scps_kind_t;

  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_ANSWERED = 3'd2,
    EV_BUSY     = 3'd3,
    EV_IDLE     = 3'd4
  } scps_event_t;

  // queue store access, one write and one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ENTRY_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } scps_mem_req_t;

  // result of one beat; id and busy are replaced by store data when ans is set
  typedef struct packed {
    scps_event_t        ev;
    logic [ID_W-1:0]    id;
    logic [CLASS_W-1:0] cls;
    logic [DUR_W-1:0]   busy;
    logic               ans;
  } scps_decision_t;

  // remaining busy ticks after answering a call of this duration
  function automatic logic [DUR_W-1:0] scps_busy_after(input logic [DUR_W-1:0] dur);
    logic [DUR_W-1:0] res;
    res = (dur == '0) ? '0 : dur - DUR_W'(1);
    return res;
  endfunction

endpackage

// ----- rtl/strict_priority_call_scheduler.sv -----
// top level of the four class strict priority call scheduler
//
// input channel (in_valid / in_ready) carries one beat per arrival or tick:
//   kind 0 is a call arrival for class_level with caller_id and service_time,
//   kind 1 is one server time tick
// output channel (out_valid / out_ready) carries exactly one result beat per
//   input beat, in order: event_res, out_caller_id, out_class, busy_left
// pipeline: the input register loads on accept, then the result register, fed
//   by the queue store read, loads when the held beat moves on
// throughput: one beat per cycle while the receiver does not stall; the decision
//   path is a short priority pick and pointer update, and the store read lands
//   in the same cycle the result register loads
// a receiver stall holds the result register; the input register still
//   takes one more beat, then in_ready drops until the result is taken
// reset clears all queues, the busy counter and both pipeline valids;
//   the entry store itself needs no clearing since only filled slots are read
// a call of zero service time is served as one tick
module strict_priority_call_scheduler import scps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [CLASS_W-1:0] class_level,
  input  logic [ID_W-1:0]    caller_id,
  input  logic [DUR_W-1:0]   service_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         event_res,
  output logic [ID_W-1:0]    out_caller_id,
  output logic [CLASS_W-1:0] out_class,
  output logic [DUR_W-1:0]   busy_left
);

  // input register
  logic               a_valid;
  scps_kind_t         a_kind;
  logic [CLASS_W-1:0] a_class;
  logic [ID_W-1:0]    a_id;
  logic [DUR_W-1:0]   a_dur;
  logic               a_fire;

  // result register
  logic           b_valid;
  scps_decision_t b_dec;

  scps_decision_t     dec;
  scps_mem_req_t      mem_req;
  logic [ENTRY_W-1:0] rd_data;

  // the held beat moves on when the result register is free or draining
  assign a_fire   = a_valid && (!b_valid || out_ready);
  assign in_ready = !a_valid || a_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_fire) begin
        b_valid <= 1'b1;
      end else if (out_ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_kind  <= scps_kind_t'(kind);
      a_class <= class_level;
      a_id    <= caller_id;
      a_dur   <= service_time;
    end
    if (a_fire) begin
      b_dec <= dec;
    end
  end

  scps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .fire         (a_fire),
    .kind         (a_kind),
    .class_level  (a_class),
    .caller_id    (a_id),
    .service_time (a_dur),
    .rd_data      (rd_data),
    .mem_req      (mem_req),
    .dec          (dec)
  );

  // read data is only loaded with an answering beat, so it holds under stall
  scps_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // answered calls take caller and duration straight from the store read
  assign out_valid     = b_valid;
  assign event_res     = b_dec.ev;
  assign out_caller_id = b_dec.ans ? rd_data[ENTRY_W-1:DUR_W] : b_dec.id;
  assign out_class     = b_dec.cls;
  assign busy_left     = b_dec.ans ? scps_busy_after(rd_data[DUR_W-1:0]) : b_dec.busy;

  // a beat leaving the input register always shows up as a result
  a_fire_to_result: assert property (@(posedge clk) disable iff (rst)
    a_fire |=> b_valid)
    else $error("accepted beat did not reach result register");

  // an empty result register never blocks the input side
  no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !b_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // busy and idle results carry no caller
  no_caller_on_busy_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_BUSY || event_res == EV_IDLE)
      |-> out_caller_id == '0 && out_class == '0)
    else $error("caller reported on busy or idle result");

  // an idle server has no remaining work
  idle_means_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_IDLE |-> busy_left == '0)
    else $error("idle result with nonzero busy count");

endmodule

// ----- rtl/scps_mem.sv -----
// queue entry store shared by all priority classes
module scps_mem import scps_pkg::*; (
  input  logic               clk,
  input  scps_mem_req_t      req,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ----- rtl/scps_ctrl.sv -----
// queue pointers, priority pick and server busy counter
module scps_ctrl import scps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  scps_kind_t         kind,
  input  logic [CLASS_W-1:0] class_level,
  input  logic [ID_W-1:0]    caller_id,
  input  logic [DUR_W-1:0]   service_time,
  input  logic [ENTRY_W-1:0] rd_data,
  output scps_mem_req_t      mem_req,
  output scps_decision_t     dec
);

  logic [SLOT_W-1:0] heads      [NUM_CLASSES];
  logic [SLOT_W-1:0] heads_next [NUM_CLASSES];
  logic [CNT_W-1:0]  counts      [NUM_CLASSES];
  logic [CNT_W-1:0]  counts_next [NUM_CLASSES];
  logic [DUR_W-1:0]  busy;
  logic [DUR_W-1:0]  busy_next;
  logic [DUR_W-1:0]  busy_eff;
  logic              fresh;

  logic [CLS_IDX_W-1:0] cls_idx;
  logic                 cls_ok;
  logic [CNT_W-1:0]     arr_count;
  logic                 arr_full;
  logic [SLOT_W:0]      tail_sum;
  logic [SLOT_W-1:0]    tail;
  logic                 pick_any;
  logic [CLS_IDX_W-1:0] pick_idx;
  logic [SLOT_W-1:0]    pick_head;

  // busy value left by a call answered in the previous beat
  assign busy_eff = fresh ? scps_busy_after(rd_data[DUR_W-1:0]) : busy;

  assign cls_idx   = CLS_IDX_W'(class_level);
  assign cls_ok    = 32'(class_level) < 32'(NUM_CLASSES);
  assign arr_count = counts[cls_idx];
  assign arr_full  = arr_count >= CNT_W'(QUEUE_DEPTH);
  assign tail_sum  = (SLOT_W+1)'(heads[cls_idx]) + (SLOT_W+1)'(arr_count);
  assign tail      = (tail_sum >= (SLOT_W+1)'(QUEUE_DEPTH)) ?
                     SLOT_W'(tail_sum - (SLOT_W+1)'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);

  // highest non-empty class wins
  always_comb begin
    pick_any = 1'b0;
    pick_idx = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (counts[c] != '0) begin
        pick_any = 1'b1;
        pick_idx = CLS_IDX_W'(c);
      end
    end
  end

  assign pick_head = heads[pick_idx];

  always_comb begin
    dec         = '{ev: EV_IDLE, id: '0, cls: '0, busy: '0, ans: 1'b0};
    mem_req     = '0;
    heads_next  = heads;
    counts_next = counts;
    busy_next   = busy_eff;
    if (kind == KIND_ARRIVAL) begin
      dec.id   = caller_id;
      dec.cls  = class_level;
      dec.busy = busy_eff;
      if (!cls_ok || arr_full) begin
        dec.ev = EV_DROPPED;
      end else begin
        dec.ev        = EV_QUEUED;
        mem_req.we    = fire;
        mem_req.waddr = {cls_idx, tail};
        mem_req.wdata = {caller_id, service_time};
        if (fire) begin
          counts_next[cls_idx] = arr_count + CNT_W'(1);
        end
      end
    end else if (busy_eff != '0) begin
      dec.ev   = EV_BUSY;
      dec.busy = busy_eff - DUR_W'(1);
      if (fire) begin
        busy_next = busy_eff - DUR_W'(1);
      end
    end else if (pick_any) begin
      dec.ev        = EV_ANSWERED;
      dec.cls       = CLASS_W'(pick_idx);
      dec.ans       = 1'b1;
      mem_req.re    = fire;
      mem_req.raddr = {pick_idx, pick_head};
      if (fire) begin
        counts_next[pick_idx] = counts[pick_idx] - CNT_W'(1);
        heads_next[pick_idx]  = (32'(pick_head) == QUEUE_DEPTH - 1) ?
                                '0 : pick_head + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        heads[c]  <= '0;
        counts[c] <= '0;
      end
      busy  <= '0;
      fresh <= 1'b0;
    end else begin
      heads  <= heads_next;
      counts <= counts_next;
      busy   <= busy_next;
      fresh  <= fire && dec.ans;
    end
  end

endmodule
